@@ rtl/lattice_monomer_diffusion_step_top_defines.svh @@
// Assertion macros shared by the RTL of the monomer diffusion block.
`ifndef LATTICE_MONOMER_DIFFUSION_STEP_TOP_DEFINES_SVH
`define LATTICE_MONOMER_DIFFUSION_STEP_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LMDS_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define LMDS_ASSERT_NXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("next-cycle check failed");

`endif

@@ rtl/lmds_pkg.sv @@
// Shared types and constants of the monomer diffusion block.
package lmds_pkg;

	localparam int GRID_SIDE_DEF = 64;

	localparam logic [1:0] OUT_EMPTY  = 2'd0;
	localparam logic [1:0] OUT_ISLAND = 2'd1;
	localparam logic [1:0] OUT_JOIN   = 2'd2;
	localparam logic [1:0] OUT_NONE   = 2'd3;

	localparam logic [1:0] DIR_COL_INC = 2'd0;
	localparam logic [1:0] DIR_ROW_INC = 2'd1;
	localparam logic [1:0] DIR_COL_DEC = 2'd2;
	localparam logic [1:0] DIR_ROW_DEC = 2'd3;

	localparam logic KIND_PLACE   = 1'b0;
	localparam logic KIND_DIFFUSE = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PMOD,
		ST_MUL,
		ST_SRD,
		ST_SWT,
		ST_HRD,
		ST_DECIDE,
		ST_DROP_MOV,
		ST_IRD,
		ST_IWT,
		ST_DROP_HIT,
		ST_RAISE,
		ST_ZSRC,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic latch;
		logic pmod_step;
		logic mul;
		logic src_rd;
		logic src_calc;
		logic h_rd;
		logic decide;
		logic idx_rd;
		logic drop_ld_slot;
		logic drop_ld_idx;
		logic drop_step;
		logic raise;
		logic zsrc;
		logic set_empty;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic empty;
		logic pmod_ok;
		logic h_zero;
		logic h_one;
		logic drop_done;
		logic clr_last;
	} stat_t;

endpackage

@@ rtl/lmds_ctrl.sv @@
// Sequencer of the monomer diffusion block.
module lmds_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  lmds_pkg::stat_t st,
	output lmds_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);

	lmds_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lmds_pkg::ST_CLEAR;
		else state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lmds_pkg::ST_CLEAR: begin
				if (st.clr_last) state_nxt = lmds_pkg::ST_IDLE;
			end
			lmds_pkg::ST_IDLE: begin
				if (start) state_nxt = lmds_pkg::ST_PMOD;
			end
			lmds_pkg::ST_PMOD: begin
				// kind is latched by now; route diffuse items
				if (st.kind != lmds_pkg::KIND_PLACE) begin
					state_nxt = st.empty ? lmds_pkg::ST_RESULT : lmds_pkg::ST_MUL;
				end else if (st.pmod_ok) begin
					state_nxt = lmds_pkg::ST_HRD;
				end
			end
			lmds_pkg::ST_MUL: state_nxt = lmds_pkg::ST_SRD;
			lmds_pkg::ST_SRD: state_nxt = lmds_pkg::ST_SWT;
			lmds_pkg::ST_SWT: state_nxt = lmds_pkg::ST_HRD;
			lmds_pkg::ST_HRD: state_nxt = lmds_pkg::ST_DECIDE;
			lmds_pkg::ST_DECIDE: begin
				if (st.h_zero) state_nxt = lmds_pkg::ST_RAISE;
				else if (st.kind != lmds_pkg::KIND_PLACE) state_nxt = lmds_pkg::ST_DROP_MOV;
				else if (st.h_one) state_nxt = lmds_pkg::ST_IRD;
				else state_nxt = lmds_pkg::ST_RAISE;
			end
			lmds_pkg::ST_DROP_MOV: begin
				if (st.drop_done) state_nxt = st.h_one ? lmds_pkg::ST_IRD : lmds_pkg::ST_RAISE;
			end
			lmds_pkg::ST_IRD: state_nxt = lmds_pkg::ST_IWT;
			lmds_pkg::ST_IWT: state_nxt = lmds_pkg::ST_DROP_HIT;
			lmds_pkg::ST_DROP_HIT: begin
				if (st.drop_done) state_nxt = lmds_pkg::ST_RAISE;
			end
			lmds_pkg::ST_RAISE: begin
				state_nxt = (st.kind != lmds_pkg::KIND_PLACE) ? lmds_pkg::ST_ZSRC
					: lmds_pkg::ST_RESULT;
			end
			lmds_pkg::ST_ZSRC: state_nxt = lmds_pkg::ST_RESULT;
			lmds_pkg::ST_RESULT: state_nxt = lmds_pkg::ST_IDLE;
			default: state_nxt = lmds_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != lmds_pkg::ST_IDLE);
		done = (state_q == lmds_pkg::ST_RESULT);
		case (state_q)
			lmds_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
			lmds_pkg::ST_IDLE: cmd.latch = start;
			lmds_pkg::ST_PMOD: begin
				if (st.kind == lmds_pkg::KIND_PLACE) cmd.pmod_step = 1'b1;
				else cmd.set_empty = st.empty;
			end
			lmds_pkg::ST_MUL: cmd.mul = 1'b1;
			lmds_pkg::ST_SRD: cmd.src_rd = 1'b1;
			lmds_pkg::ST_SWT: cmd.src_calc = 1'b1;
			lmds_pkg::ST_HRD: cmd.h_rd = 1'b1;
			lmds_pkg::ST_DECIDE: begin
				cmd.decide = 1'b1;
				cmd.drop_ld_slot = !st.h_zero && (st.kind != lmds_pkg::KIND_PLACE);
			end
			lmds_pkg::ST_DROP_MOV: cmd.drop_step = 1'b1;
			lmds_pkg::ST_IRD: cmd.idx_rd = 1'b1;
			lmds_pkg::ST_IWT: cmd.drop_ld_idx = 1'b1;
			lmds_pkg::ST_DROP_HIT: cmd.drop_step = 1'b1;
			lmds_pkg::ST_RAISE: cmd.raise = 1'b1;
			lmds_pkg::ST_ZSRC: cmd.zsrc = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

@@ rtl/lmds_dp.sv @@
// Datapath of the monomer diffusion block: grid, list and index memories.
module lmds_dp #(
	parameter int GRID_SIDE = lmds_pkg::GRID_SIDE_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lmds_pkg::cmd_t  cmd,
	output lmds_pkg::stat_t st,
	input  logic            kind,
	input  logic [5:0]      place_row,
	input  logic [5:0]      place_col,
	input  logic [15:0]     random_fraction,
	input  logic [1:0]      direction,
	output logic [1:0]      outcome,
	output logic [5:0]      dest_row,
	output logic [5:0]      dest_col,
	output logic [12:0]     monomers_left
);

	localparam int CELLS = GRID_SIDE * GRID_SIDE;
	localparam int RW = $clog2(GRID_SIDE);
	localparam int AW = $clog2(CELLS);
	localparam int CW = $clog2(CELLS + 1);
	localparam int PW = 2 * RW;

	logic [7:0]    hgt_mem [CELLS];
	logic [PW-1:0] pos_mem [CELLS];
	logic [AW-1:0] idx_mem [CELLS];

	logic          kind_q;
	logic [5:0]    prow_q, pcol_q;
	logic [15:0]   frac_q;
	logic [1:0]    dir_q;
	logic [RW-1:0] drow_q, dcol_q, srow_q, scol_q;
	logic [AW-1:0] slot_q, clr_q, wk_q;
	logic [CW-1:0] count_q, k_q;
	logic          act_q, pv_q;
	logic [7:0]    hgt_rd_q;
	logic [PW-1:0] pos_rd_q;
	logic [AW-1:0] idx_rd_q;
	logic [1:0]    outcome_q;

	logic [AW-1:0] dest_addr, src_addr, drop_cell;
	logic [CW-1:0] k_nxt;
	logic          more, h0, h1, room;
	logic [15+CW:0] prod;
	logic [RW-1:0] nrow, ncol, prow_r, pcol_r;

	assign dest_addr = AW'(drow_q) * AW'(GRID_SIDE) + AW'(dcol_q);
	assign src_addr  = AW'(srow_q) * AW'(GRID_SIDE) + AW'(scol_q);
	assign drop_cell = AW'(pos_rd_q[PW-1:RW]) * AW'(GRID_SIDE) + AW'(pos_rd_q[RW-1:0]);
	assign k_nxt = k_q + CW'(1);
	assign more  = k_nxt < count_q;
	assign h0 = (hgt_rd_q == 8'd0);
	assign h1 = (hgt_rd_q == 8'd1);
	assign room = count_q < CW'(CELLS);
	assign prod = {{CW{1'b0}}, frac_q} * {16'd0, count_q};
	assign prow_r = RW'(prow_q);
	assign pcol_r = RW'(pcol_q);

	assign st.kind      = kind_q;
	assign st.empty     = (count_q == '0);
	assign st.pmod_ok   = (32'(prow_q) < GRID_SIDE) && (32'(pcol_q) < GRID_SIDE);
	assign st.h_zero    = h0;
	assign st.h_one     = h1;
	assign st.drop_done = !pv_q && !more;
	assign st.clr_last  = (clr_q == AW'(CELLS - 1));

	// neighbor of the source cell, wrapping at the grid edge
	always_comb begin
		nrow = pos_rd_q[PW-1:RW];
		ncol = pos_rd_q[RW-1:0];
		case (dir_q)
			lmds_pkg::DIR_COL_INC: ncol = (ncol == RW'(GRID_SIDE - 1)) ? '0 : ncol + RW'(1);
			lmds_pkg::DIR_ROW_INC: nrow = (nrow == RW'(GRID_SIDE - 1)) ? '0 : nrow + RW'(1);
			lmds_pkg::DIR_COL_DEC: ncol = (ncol == '0) ? RW'(GRID_SIDE - 1) : ncol - RW'(1);
			lmds_pkg::DIR_ROW_DEC: nrow = (nrow == '0) ? RW'(GRID_SIDE - 1) : nrow - RW'(1);
			default: nrow = pos_rd_q[PW-1:RW];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			clr_q   <= '0;
			pv_q    <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);
			if (cmd.decide && kind_q == lmds_pkg::KIND_PLACE && h0 && room)
				count_q <= count_q + CW'(1);
			if (cmd.drop_ld_slot || cmd.drop_ld_idx) pv_q <= 1'b0;
			if (cmd.drop_step) begin
				pv_q <= more;
				if (!pv_q && !more) count_q <= count_q - CW'(act_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= kind;
			prow_q <= place_row;
			pcol_q <= place_col;
			frac_q <= random_fraction;
			dir_q  <= direction;
		end
		if (cmd.pmod_step) begin
			if (st.pmod_ok) begin
				drow_q <= prow_r;
				dcol_q <= pcol_r;
			end else begin
				if (32'(prow_q) >= GRID_SIDE) prow_q <= prow_q - 6'(GRID_SIDE);
				if (32'(pcol_q) >= GRID_SIDE) pcol_q <= pcol_q - 6'(GRID_SIDE);
			end
		end
		if (cmd.mul) slot_q <= AW'(prod >> 16);
		if (cmd.src_calc) begin
			srow_q <= pos_rd_q[PW-1:RW];
			scol_q <= pos_rd_q[RW-1:0];
			drow_q <= nrow;
			dcol_q <= ncol;
		end
		if (cmd.set_empty) begin
			outcome_q <= lmds_pkg::OUT_NONE;
			drow_q <= '0;
			dcol_q <= '0;
		end
		if (cmd.decide) begin
			outcome_q <= h0 ? lmds_pkg::OUT_EMPTY : h1 ? lmds_pkg::OUT_ISLAND
				: lmds_pkg::OUT_JOIN;
		end
		if (cmd.drop_ld_slot) begin
			k_q   <= CW'(slot_q);
			act_q <= CW'(slot_q) < count_q;
		end
		if (cmd.drop_ld_idx) begin
			k_q   <= CW'(idx_rd_q);
			act_q <= CW'(idx_rd_q) < count_q;
		end
		if (cmd.drop_step && more) begin
			wk_q <= k_q[AW-1:0];
			k_q  <= k_nxt;
		end
	end

	// height memory: clear sweep, raise target, zero source
	always_ff @(posedge clk) begin
		if (cmd.clr_step) hgt_mem[clr_q] <= 8'd0;
		else if (cmd.raise)
			hgt_mem[dest_addr] <= (hgt_rd_q == 8'hFF) ? 8'hFF : hgt_rd_q + 8'd1;
		else if (cmd.zsrc && src_addr != dest_addr) hgt_mem[src_addr] <= 8'd0;
		if (cmd.h_rd) hgt_rd_q <= hgt_mem[dest_addr];
	end

	// monomer list
	always_ff @(posedge clk) begin
		if (cmd.decide && h0) begin
			if (kind_q != lmds_pkg::KIND_PLACE) pos_mem[slot_q] <= {drow_q, dcol_q};
			else if (room) pos_mem[count_q[AW-1:0]] <= {drow_q, dcol_q};
		end else if (cmd.drop_step && pv_q) begin
			pos_mem[wk_q] <= pos_rd_q;
		end
		if (cmd.src_rd) pos_rd_q <= pos_mem[slot_q];
		else if (cmd.drop_step && more) pos_rd_q <= pos_mem[k_nxt[AW-1:0]];
	end

	// reverse index from cell to list slot
	always_ff @(posedge clk) begin
		if (cmd.decide && h0) begin
			if (kind_q != lmds_pkg::KIND_PLACE) idx_mem[dest_addr] <= slot_q;
			else if (room) idx_mem[dest_addr] <= count_q[AW-1:0];
		end else if (cmd.drop_step && pv_q) begin
			idx_mem[drop_cell] <= wk_q;
		end
		if (cmd.idx_rd) idx_rd_q <= idx_mem[dest_addr];
	end

	assign outcome = outcome_q;
	assign dest_row = 6'(drow_q);
	assign dest_col = 6'(dcol_q);
	assign monomers_left = 13'(count_q);

endmodule

@@ rtl/lattice_monomer_diffusion_step_top.sv @@
// Top level of the monomer diffusion block: sequencer plus datapath.
// A place request takes modulo steps until the position lies on the grid (none at GRID_SIDE
//   64); a diffuse request on an empty list goes straight to the result. Each list removal
//   shifts the later entries down one slot; removing a hit monomer first reads its index.
// One request at a time; busy is high from acceptance through the result strobe, and the
//   next request is taken in the cycle after the strobe at the earliest. The result cannot stall.
// After reset a clearing pass writes every grid cell, with busy high.
`include "lattice_monomer_diffusion_step_top_defines.svh"
module lattice_monomer_diffusion_step_top #(
	parameter int GRID_SIDE = lmds_pkg::GRID_SIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic        kind,
	input  logic [5:0]  place_row,
	input  logic [5:0]  place_col,
	input  logic [15:0] random_fraction,
	input  logic [1:0]  direction,
	output logic [1:0]  outcome,
	output logic [5:0]  dest_row,
	output logic [5:0]  dest_col,
	output logic [12:0] monomers_left
);

	lmds_pkg::cmd_t  cmd;
	lmds_pkg::stat_t st;

	// sequence the grid and list accesses
	lmds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// hold the grid, the list and the reverse index
	lmds_dp #(.GRID_SIDE(GRID_SIDE)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.kind            (kind),
		.place_row       (place_row),
		.place_col       (place_col),
		.random_fraction (random_fraction),
		.direction       (direction),
		.outcome         (outcome),
		.dest_row        (dest_row),
		.dest_col        (dest_col),
		.monomers_left   (monomers_left)
	);

	`LMDS_ASSERT_IMP(a_done_busy, clk, arst_n, done, busy)
	`LMDS_ASSERT_NXT(a_done_once, clk, arst_n, done, !done)
	`LMDS_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`LMDS_ASSERT_IMP(a_none_zero, clk, arst_n, done && outcome == lmds_pkg::OUT_NONE,
		monomers_left == 13'd0)

endmodule
